### hdl/tmt_pkg.sv
// shared types and constants of the tinymt32 generator
// no dependencies; imported by every module of the block
package tmt_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;

    localparam logic [DATA_W-1:0] MUL_CONST      = 32'd1812433253;
    localparam logic [DATA_W-1:0] LOW31_MASK     = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] RST_SEED       = 32'h0000_0000;
    localparam logic [DATA_W-1:0] RST_MATRIX_ONE = 32'h8f70_11ee;
    localparam logic [DATA_W-1:0] RST_MATRIX_TWO = 32'hfc78_ff1f;
    localparam logic [DATA_W-1:0] RST_TEMPER     = 32'h3793_fdff;

    // register index within the configuration space
    typedef enum logic [1:0] {
        REG_SEED       = 2'd0,
        REG_MATRIX_ONE = 2'd1,
        REG_MATRIX_TWO = 2'd2,
        REG_TEMPER     = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_WARM,
        ST_GEN,
        ST_TEMPER
    } t_core_state;

    // request as classified by the front queue
    typedef struct packed {
        logic [DATA_W-1:0] divisor;
        logic              use_mod;
    } t_req;

    // job handed from the generator to the remainder unit
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] divisor;
        logic              use_mod;
    } t_div_req;

endpackage

### hdl/tmt_queue.sv
// front part: two-entry request queue that accepts and classifies requests
// depends on tmt_pkg
module tmt_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [tmt_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_req_valid,
    output tmt_pkg::t_req              o_req,
    input  logic                       i_pop
);
    import tmt_pkg::*;

    t_req       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_stall     = (r_count == 2'd2);
    assign o_req_valid = (r_count != 2'd0);
    assign o_req       = r_entry[r_rd_ptr];
    assign push        = i_valid && !o_stall;
    assign pop         = i_pop && o_req_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // zero divisor marks a request that returns the full value
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr].divisor <= i_divisor;
            r_entry[r_wr_ptr].use_mod <= (i_divisor != '0);
        end
    end

endmodule

### hdl/tmt_core.sv
// back part: state words, seeding sequencer, advance and tempering
// depends on tmt_pkg
module tmt_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_reseed,
    input  logic [tmt_pkg::DATA_W-1:0] i_seed,
    input  logic [tmt_pkg::DATA_W-1:0] i_matrix_one,
    input  logic [tmt_pkg::DATA_W-1:0] i_matrix_two,
    input  logic [tmt_pkg::DATA_W-1:0] i_temper,
    input  logic                       i_req_valid,
    input  tmt_pkg::t_req              i_req,
    output logic                       o_pop,
    output logic                       o_div_valid,
    output tmt_pkg::t_div_req          o_div_req,
    input  logic                       i_div_ready
);
    import tmt_pkg::*;

    t_core_state       r_state, n_state;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_seed_pend, n_seed_pend;
    logic [DATA_W-1:0] r_st0, r_st1, r_st2, r_st3;
    logic [DATA_W-1:0] n_st0, n_st1, n_st2, n_st3;

    logic [DATA_W-1:0] adv_x, adv_x2, adv_y, adv0, adv1, adv2, adv3;
    logic [DATA_W-1:0] mix_p, mix_prod, mix_word;
    logic [DATA_W-1:0] tmp_sum, tmp_val;

    // one state advance
    always_comb begin
        adv_x  = (r_st0 & LOW31_MASK) ^ r_st1 ^ r_st2;
        adv_x2 = adv_x ^ (adv_x << 1);
        adv_y  = r_st3 ^ (r_st3 >> 1) ^ adv_x2;
        adv0   = r_st1;
        adv1   = r_st2;
        adv2   = adv_x2 ^ (adv_y << 10);
        adv3   = adv_y;
        if (adv_y[0]) begin
            adv1 = adv1 ^ i_matrix_one;
            adv2 = adv2 ^ i_matrix_two;
        end
    end

    // mixing step on rotated words: target in st0, previous word in st3
    assign mix_p    = r_st3 ^ (r_st3 >> 30);
    assign mix_prod = MUL_CONST * mix_p;
    assign mix_word = r_st0 ^ ({{(DATA_W-3){1'b0}}, r_cnt} + mix_prod);

    // tempering
    assign tmp_sum = r_st0 + (r_st2 >> 8);
    assign tmp_val = r_st3 ^ tmp_sum ^ (tmp_sum[0] ? i_temper : '0);

    assign o_div_req.value   = tmp_val;
    assign o_div_req.divisor = i_req.divisor;
    assign o_div_req.use_mod = i_req.use_mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 3'd0;
            r_seed_pend <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_seed_pend <= n_seed_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st0 <= n_st0;
        r_st1 <= n_st1;
        r_st2 <= n_st2;
        r_st3 <= n_st3;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_seed_pend = r_seed_pend || i_reseed;
        n_st0       = r_st0;
        n_st1       = r_st1;
        n_st2       = r_st2;
        n_st3       = r_st3;
        o_pop       = 1'b0;
        o_div_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (r_seed_pend) begin
                        // rotated load so the first target sits in st0
                        n_st0   = i_matrix_one;
                        n_st1   = i_matrix_two;
                        n_st2   = i_temper;
                        n_st3   = i_seed;
                        n_cnt   = 3'd1;
                        n_state = ST_MIX;
                    end else begin
                        n_state = ST_GEN;
                    end
                end
            end
            ST_MIX: begin
                n_st0 = r_st1;
                n_st1 = r_st2;
                n_st2 = r_st3;
                n_st3 = mix_word;
                if (r_cnt == 3'd7) begin
                    n_cnt   = 3'd0;
                    n_state = ST_WARM;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_WARM: begin
                n_st0 = adv0;
                n_st1 = adv1;
                n_st2 = adv2;
                n_st3 = adv3;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_seed_pend = 1'b0;
                    n_state     = ST_GEN;
                end
            end
            ST_GEN: begin
                n_st0   = adv0;
                n_st1   = adv1;
                n_st2   = adv2;
                n_st3   = adv3;
                n_state = ST_TEMPER;
            end
            ST_TEMPER: begin
                o_div_valid = 1'b1;
                if (i_div_ready) begin
                    o_pop   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/tmt_divider.sv
// back part: bit-serial remainder unit with the output register
// depends on tmt_pkg
module tmt_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  tmt_pkg::t_div_req          i_req,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic [tmt_pkg::DATA_W-1:0] o_value,
    input  logic                       i_stall
);
    import tmt_pkg::*;

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [DATA_W-1:0] r_rem, r_dvd, r_dvs, r_val;
    logic              r_use_mod;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;

    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic [DATA_W-1:0] rem_next;
    logic              last;
    logic              step_en;

    assign shifted  = {r_rem, r_dvd[DATA_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, r_dvs};
    assign rem_next = diff[DATA_W+1] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
    assign last     = (r_cnt == 5'd31);
    // the final step waits while a finished result is still held
    assign step_en  = r_busy && !(last && r_out_valid && i_stall);

    assign o_ready = !r_busy;
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (step_en) begin
                r_cnt <= r_cnt + 5'd1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (step_en && last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem     <= '0;
            r_dvd     <= i_req.value;
            r_val     <= i_req.value;
            r_dvs     <= i_req.divisor;
            r_use_mod <= i_req.use_mod;
        end else if (step_en) begin
            r_rem <= rem_next;
            r_dvd <= r_dvd << 1;
        end
        if (step_en && last) begin
            r_out_value <= r_use_mod ? rem_next : r_val;
        end
    end

endmodule

### hdl/tinymt32_random_generator.sv
// tinymt32 generator: the first request after reset or a seed write runs the seeding
// first (7 mixing multiplies, 8 warm-up advances), then does its own work
// each request goes through core pickup, advance, temper and hand-off, then 32
// remainder steps into the output register; while requests wait, the core prepares
// the next value during the remainder steps, and the remainder unit sets the pace;
// synchronous active-low reset clears control, register file to defaults, seeding pending
module tinymt32_random_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tmt_pkg::ADDR_W-1:0] paddr,
    input  logic [tmt_pkg::DATA_W-1:0] pwdata,
    output logic [tmt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // request channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [tmt_pkg::DATA_W-1:0] i_divisor,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [tmt_pkg::DATA_W-1:0] o_value
);
    import tmt_pkg::*;

    logic [DATA_W-1:0] r_seed, r_matrix_one, r_matrix_two, r_temper;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    t_req              q_req;
    logic              q_valid;
    logic              q_pop;
    t_div_req          div_req;
    logic              div_start;
    logic              div_ready;

    // register file, written on the access phase of a transfer
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= RST_SEED;
            r_matrix_one <= RST_MATRIX_ONE;
            r_matrix_two <= RST_MATRIX_TWO;
            r_temper     <= RST_TEMPER;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SEED:       r_seed       <= pwdata;
                REG_MATRIX_ONE: r_matrix_one <= pwdata;
                REG_MATRIX_TWO: r_matrix_two <= pwdata;
                REG_TEMPER:     r_temper     <= pwdata;
                default:        r_seed       <= r_seed;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SEED:       prdata = r_seed;
            REG_MATRIX_ONE: prdata = r_matrix_one;
            REG_MATRIX_TWO: prdata = r_matrix_two;
            REG_TEMPER:     prdata = r_temper;
            default:        prdata = '0;
        endcase
    end

    // front: request queue, lets requests in while the back end is busy
    tmt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_divisor   (i_divisor),
        .o_req_valid (q_valid),
        .o_req       (q_req),
        .i_pop       (q_pop)
    );

    // back: seeding, advance and tempering; a seed write re-arms seeding,
    // which then runs on the next request with the registers as they are
    tmt_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_reseed     (cfg_wr && (cfg_idx == REG_SEED)),
        .i_seed       (r_seed),
        .i_matrix_one (r_matrix_one),
        .i_matrix_two (r_matrix_two),
        .i_temper     (r_temper),
        .i_req_valid  (q_valid),
        .i_req        (q_req),
        .o_pop        (q_pop),
        .o_div_valid  (div_start),
        .o_div_req    (div_req),
        .i_div_ready  (div_ready)
    );

    // back: remainder unit, one quotient bit per cycle unless the final step waits on a
    // stalled result; holds the result in its output register until the transfer completes
    tmt_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_req   (div_req),
        .o_ready (div_ready),
        .o_valid (o_valid),
        .o_value (o_value),
        .i_stall (i_stall)
    );

endmodule

### hdl/tmt_checker.sv
// port-level checks of the tinymt32 generator, bound to the top level
// depends on tmt_pkg and tinymt32_random_generator
module tmt_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       pready,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [tmt_pkg::DATA_W-1:0] o_value
);
    import tmt_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value))
        else $error("result changed while stalled");

    // reset empties the queue and the output, and no result follows at once
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall ##1 !o_valid)
        else $error("reset did not clear the channels");

    // the queue only fills up through a request transfer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid && !o_stall))
        else $error("stall rose without a request transfer");

    // configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind tinymt32_random_generator tmt_checker u_tmt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .pready  (pready),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_value (o_value)
);

### bench/tb.sv
// self-checking bench for tinymt32_random_generator: register access and request/result checks
// carries its own generator model; depends only on tmt_pkg and the block's rtl
`timescale 1ns / 100ps

module tb;
    import tmt_pkg::*;

    // generator arithmetic, kept local so the bench does not inherit rtl constants
    localparam logic [31:0] MIX_MUL   = 32'd1812433253;
    localparam logic [31:0] KEEP_LOW31 = 32'h7fff_ffff;
    localparam logic [31:0] DEF_SEED  = 32'h0000_0000;
    localparam logic [31:0] DEF_MAT1  = 32'h8f70_11ee;
    localparam logic [31:0] DEF_MAT2  = 32'hfc78_ff1f;
    localparam logic [31:0] DEF_TMAT  = 32'h3793_fdff;

    localparam int SETTLE_CYCLES = 40;      // past the block's per-request latency
    localparam int CYCLE_LIMIT   = 500000;  // several times the slowest legal run
    localparam int NUM_PROBES    = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_divisor;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_value;

    tinymt32_random_generator u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_divisor (i_divisor),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_value   (o_value)
    );

    // directed requests; a fixed row carries a value that needs no model
    typedef struct packed {
        logic [31:0] divisor;
        logic        fixed;
        logic [31:0] value;
    } t_probe;

    t_probe probes [0:NUM_PROBES-1] = '{
        '{32'h0000_0000, 1'b0, 32'h0},   // first request pays for seeding
        '{32'h0000_0001, 1'b1, 32'h0},   // anything mod 1 is zero
        '{32'hffff_ffff, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 32'h0},
        '{32'h0000_0002, 1'b0, 32'h0},
        '{32'h0000_0003, 1'b0, 32'h0},
        '{32'h0000_0007, 1'b0, 32'h0},
        '{32'h0000_000a, 1'b0, 32'h0},
        '{32'h0001_0000, 1'b0, 32'h0},
        '{32'h7fff_ffff, 1'b0, 32'h0},
        '{32'hffff_fffe, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 32'h0},
        '{32'haaaa_aaaa, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b0, 32'h0},   // full width value again
        '{32'h0000_0001, 1'b1, 32'h0},
        '{32'h0000_0000, 1'b0, 32'h0}
    };

    // model copy of the register file and generator words
    logic [31:0] cfg_seed;
    logic [31:0] cfg_mat1;
    logic [31:0] cfg_mat2;
    logic [31:0] cfg_tmat;
    logic [31:0] mt_word [4];
    logic        seed_pending;

    logic [31:0] exp_values [$];   // predicted values, oldest first
    int          errors;
    bit          idling;           // random gaps and stalls enabled
    int          cycle_count;

    // ---------------------------------------------------------------- model

    function automatic void mt_reset();
        cfg_seed     = DEF_SEED;
        cfg_mat1     = DEF_MAT1;
        cfg_mat2     = DEF_MAT2;
        cfg_tmat     = DEF_TMAT;
        mt_word      = '{32'h0, 32'h0, 32'h0, 32'h0};
        seed_pending = 1'b1;
    endfunction

    // one state advance of the twister
    function automatic void mt_advance();
        logic [31:0] x;
        logic [31:0] y;
        x = (mt_word[0] & KEEP_LOW31) ^ mt_word[1] ^ mt_word[2];
        y = mt_word[3];
        x = x ^ (x << 1);
        y = y ^ (y >> 1) ^ x;
        mt_word[0] = mt_word[1];
        mt_word[1] = mt_word[2];
        mt_word[2] = x ^ (y << 10);
        mt_word[3] = y;
        if (y[0]) begin
            mt_word[1] = mt_word[1] ^ cfg_mat1;
            mt_word[2] = mt_word[2] ^ cfg_mat2;
        end
    endfunction

    function automatic logic [31:0] mt_temper();
        logic [31:0] sum;
        logic [31:0] t;
        sum = mt_word[0] + (mt_word[2] >> 8);
        t = mt_word[3] ^ sum;
        if (sum[0])
            t = t ^ cfg_tmat;
        return t;
    endfunction

    // seven mixing steps, then eight warm-up advances, from the current registers
    function automatic void mt_seed();
        logic [31:0] p;
        mt_word = '{cfg_seed, cfg_mat1, cfg_mat2, cfg_tmat};
        for (int unsigned k = 1; k < 8; k++) begin
            p = mt_word[(k - 1) & 3];
            mt_word[k & 3] = mt_word[k & 3] ^ (32'(k) + MIX_MUL * (p ^ (p >> 30)));
        end
        for (int k = 0; k < 8; k++)
            mt_advance();
        seed_pending = 1'b0;
    endfunction

    // value the block returns for one request
    function automatic logic [31:0] mt_next(input logic [31:0] divisor);
        logic [31:0] v;
        if (seed_pending)
            mt_seed();
        mt_advance();
        v = mt_temper();
        if (divisor != 32'h0)
            v = v % divisor;
        return v;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // mix of zero, small, power-of-two, near-max and full-range divisors
    function automatic logic [31:0] pick_divisor();
        logic [31:0] d;
        case ($urandom_range(0, 7))
            0: begin
                d = 32'h0;
            end
            1: begin
                d = $urandom_range(1, 16);
            end
            2: begin
                d = $urandom_range(1, 1000);
            end
            3: begin
                d = 32'h1 << $urandom_range(0, 31);
            end
            4: begin
                d = 32'hffff_ffff - $urandom_range(0, 3);
            end
            default: begin
                d = $urandom;
            end
        endcase
        return d;
    endfunction

    // one request transfer; prediction taken at the accepting edge
    task automatic send_request(input logic [31:0] divisor, input logic fixed,
                                input logic [31:0] fixed_value);
        logic [31:0] predicted;
        if (idling && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_divisor <= divisor;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predicted = mt_next(divisor);
        exp_values.push_back(fixed ? fixed_value : predicted);
    endtask

    // apb writes and reads leave psel high so back-to-back transfers need no idle
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_SEED: begin
                cfg_seed     = data;
                seed_pending = 1'b1;
            end
            REG_MATRIX_ONE: begin
                cfg_mat1 = data;
            end
            REG_MATRIX_TWO: begin
                cfg_mat2 = data;
            end
            default: begin
                cfg_tmat = data;
            end
        endcase
    endtask

    task automatic reg_read(input t_reg_idx idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read back all four registers against the model copy
    task automatic check_regs();
        logic [31:0] got;
        logic [31:0] want [4];
        t_reg_idx    idx;
        want = '{cfg_seed, cfg_mat1, cfg_mat2, cfg_tmat};
        for (int k = 0; k < 4; k++) begin
            idx = t_reg_idx'(k);
            reg_read(idx, got);
            if (got !== want[k]) begin
                $error("%s: expected %h, actual %h", idx.name(), want[k], got);
                errors++;
            end
        end
        bus_release();
    endtask

    // let every outstanding result arrive, then let the pipeline settle
    task automatic wait_drained();
        while (exp_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input bit with_idling);
        idling = with_idling;
        for (int k = 0; k < count; k++)
            send_request(pick_divisor(), 1'b0, 32'h0);
        i_valid <= 1'b0;
        wait_drained();
    endtask

    // ---------------------------------------------------------------- clock

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog on total run length
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- results

    // compares each result transfer with the oldest prediction and drives the
    // stall in bursts of random length while idling is on
    initial begin : result_side
        int          stall_left;
        logic [31:0] want;
        stall_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                if (exp_values.size() == 0) begin
                    $error("value: expected none, actual %h", o_value);
                    errors++;
                end else begin
                    want = exp_values.pop_front();
                    if (o_value !== want) begin
                        $error("value: expected %h, actual %h", want, o_value);
                        errors++;
                    end
                end
            end
            if (stall_left == 0 && idling && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 17);
            i_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        // every input known from time zero
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = 32'h0;
        i_valid   = 1'b0;
        i_divisor = 32'h0;
        errors    = 0;
        idling    = 1'b0;
        mt_reset();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults after reset
        check_regs();

        // directed requests on the reset configuration
        idling = 1'b1;
        for (int k = 0; k < NUM_PROBES; k++)
            send_request(probes[k].divisor, probes[k].fixed, probes[k].value);
        i_valid <= 1'b0;
        wait_drained();

        // top seed with zero matrices; matrices written after the seed still
        // take part in the pending seeding
        reg_write(REG_SEED, 32'hffff_ffff);
        reg_write(REG_MATRIX_ONE, 32'h0);
        reg_write(REG_MATRIX_TWO, 32'h0);
        reg_write(REG_TEMPER, 32'h0);
        bus_release();
        check_regs();
        run_random(150, 1'b1);

        // all-ones matrices without a new seed: no reseed, new words apply at once
        reg_write(REG_MATRIX_ONE, 32'hffff_ffff);
        reg_write(REG_MATRIX_TWO, 32'hffff_ffff);
        reg_write(REG_TEMPER, 32'hffff_ffff);
        bus_release();
        check_regs();
        run_random(150, 1'b1);

        // fully random configuration
        reg_write(REG_SEED, $urandom);
        reg_write(REG_MATRIX_ONE, $urandom);
        reg_write(REG_MATRIX_TWO, $urandom);
        reg_write(REG_TEMPER, $urandom);
        bus_release();
        check_regs();
        run_random(150, 1'b1);

        // tempering word alone changes mid-stream
        reg_write(REG_TEMPER, $urandom);
        bus_release();
        run_random(100, 1'b0);

        // back to the defaults with a zero seed: replays the reset sequence
        reg_write(REG_SEED, DEF_SEED);
        reg_write(REG_MATRIX_ONE, DEF_MAT1);
        reg_write(REG_MATRIX_TWO, DEF_MAT2);
        reg_write(REG_TEMPER, DEF_TMAT);
        bus_release();
        check_regs();
        run_random(150, 1'b1);

        // seed of one, random matrices written ahead of the seed
        reg_write(REG_MATRIX_ONE, $urandom);
        reg_write(REG_MATRIX_TWO, $urandom);
        reg_write(REG_TEMPER, $urandom);
        reg_write(REG_SEED, 32'h1);
        bus_release();
        check_regs();
        run_random(150, 1'b1);

        // reseed only, full rate
        reg_write(REG_SEED, $urandom);
        bus_release();
        run_random(100, 1'b0);

        // closing stretch without gaps or stalls
        reg_write(REG_SEED, $urandom);
        reg_write(REG_MATRIX_TWO, $urandom);
        bus_release();
        check_regs();
        run_random(150, 1'b0);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
